@@ hw/rtl/lae_pkg.sv @@
// Shared types and constants for the linear ADSR envelope.
package lae_pkg;

  localparam int LEN_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int LEVEL_W   = 16;
  localparam int PHASE_W   = 3;
  localparam int SEG_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 8'd3;

  // segment codes (low two bits of the segment counter)
  localparam logic [1:0] SEG_ATTACK  = 2'd0;
  localparam logic [1:0] SEG_DECAY   = 2'd1;
  localparam logic [1:0] SEG_SUSTAIN = 2'd2;
  localparam logic [1:0] SEG_RELEASE = 2'd3;

  // segment counter values
  localparam logic [SEG_W-1:0] SEGCNT_LAST     = 3'd4;
  localparam logic [SEG_W-1:0] SEGCNT_FINISHED = 3'd5;

  localparam logic [PHASE_W-1:0] PHASE_FINISHED = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_RELEASE  = 3'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/linear_adsr_envelope.sv @@
// Linear four-segment ADSR envelope with a shared bit-serial step divider.
// Flow: an accepted tick runs through ST_ACC, ST_MUL and ST_OUT into the result register,
//   passing ST_DIV first when it starts an attack, decay or release segment of nonzero length
//   (ACC_FRAC_BITS - LENGTH_SHIFT + 1 = 23 quotient bits at the defaults). No new tick is taken
//   meanwhile: in_stall stays high, also while the result waits on out_stall.
// Reset (rst, synchronous): lengths return to 16, envelope state clears.
module linear_adsr_envelope #(
  parameter int LENGTH_SHIFT  = 8,
  parameter int ACC_FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 start_req,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lae_pkg::LEVEL_W-1:0]          level,
  output logic [lae_pkg::LEVEL_W-1:0]          level_squared,
  output logic [lae_pkg::PHASE_W-1:0]          phase_now,
  output logic                                 done_res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lae_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lae_pkg::LEN_W-1:0]            cfg_data
);

  localparam int LW = lae_pkg::LEN_W;
  localparam int TW = LW + LENGTH_SHIFT;             // ticks_left
  localparam int AW = ACC_FRAC_BITS + 1;             // level accumulator
  localparam int SW = ACC_FRAC_BITS + 2;             // signed step
  localparam int QW = ACC_FRAC_BITS - LENGTH_SHIFT + 1;  // quotient
  localparam int CW = $clog2(QW + 1);

  localparam logic [AW-1:0] ACC_FULL  = {1'b1, {ACC_FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] STEP_FULL = {2'b01, {ACC_FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] STEP_HALF = {3'b001, {(ACC_FRAC_BITS-1){1'b0}}};
  localparam logic [QW-1:0] DVD_FULL  = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] DVD_HALF  = {2'b01, {(QW-2){1'b0}}};

  lae_pkg::state_t state, state_next;

  logic [LW-1:0] attack_len, decay_len, sustain_len, release_len;

  logic [lae_pkg::SEG_W-1:0] seg;
  logic [TW-1:0]             ticks;
  logic [AW-1:0]             acc;
  logic [SW-1:0]             step;

  logic [QW-1:0] dvd;
  logic [LW-1:0] rem;
  logic [LW-1:0] div_len;
  logic          div_neg;
  logic [CW-1:0] div_cnt;

  logic [lae_pkg::LEVEL_W-1:0] lvl;
  logic [lae_pkg::LEVEL_W-1:0] sq;
  logic [lae_pkg::PHASE_W-1:0] phase_r;
  logic                        done_r;

  logic in_take, out_load;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == lae_pkg::ST_OUT) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len  <= LW'(16);
      decay_len   <= LW'(16);
      sustain_len <= LW'(16);
      release_len <= LW'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lae_pkg::CFG_ATTACK:  attack_len  <= cfg_data;
        lae_pkg::CFG_DECAY:   decay_len   <= cfg_data;
        lae_pkg::CFG_SUSTAIN: sustain_len <= cfg_data;
        lae_pkg::CFG_RELEASE: release_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick entry: apply start, count down, pick the next segment
  logic [lae_pkg::SEG_W-1:0] seg_a, seg_n;
  logic [TW-1:0]             tk_a, tk_d, tk_n;
  logic [AW-1:0]             acc_a;
  logic [SW-1:0]             step_a, step_n;
  logic [LW-1:0]             len_sel;
  logic                      launch;
  logic [QW-1:0]             dvd_init;
  logic                      neg_init;

  always_comb begin
    seg_a    = start_req ? '0 : seg;
    tk_a     = start_req ? '0 : ticks;
    acc_a    = start_req ? '0 : acc;
    step_a   = start_req ? '0 : step;
    seg_n    = seg_a;
    tk_n     = tk_a;
    step_n   = step_a;
    launch   = 1'b0;
    dvd_init = DVD_FULL;
    neg_init = 1'b0;
    tk_d     = (tk_a != '0) ? tk_a - TW'(1) : tk_a;
    case (seg_a[1:0])
      lae_pkg::SEG_ATTACK:  len_sel = attack_len;
      lae_pkg::SEG_DECAY:   len_sel = decay_len;
      lae_pkg::SEG_SUSTAIN: len_sel = sustain_len;
      default:              len_sel = release_len;
    endcase
    if (seg_a < lae_pkg::SEGCNT_FINISHED) begin
      tk_n = tk_d;
      if (tk_d == '0) begin
        if (seg_a < lae_pkg::SEGCNT_LAST) begin
          seg_n = seg_a + 3'd1;
          if (len_sel == '0) begin
            // zero-length segment: one tick, whole change at once
            tk_n = TW'(1);
            if (seg_a[1:0] == lae_pkg::SEG_ATTACK)       step_n = STEP_FULL;
            else if (seg_a[1:0] == lae_pkg::SEG_SUSTAIN) step_n = '0;
            else                                         step_n = -STEP_HALF;
          end else begin
            tk_n = {len_sel, {LENGTH_SHIFT{1'b0}}};
            if (seg_a[1:0] == lae_pkg::SEG_SUSTAIN) begin
              step_n = '0;
            end else begin
              launch   = 1'b1;
              dvd_init = (seg_a[1:0] == lae_pkg::SEG_ATTACK) ? DVD_FULL : DVD_HALF;
              neg_init = (seg_a[1:0] != lae_pkg::SEG_ATTACK);
            end
          end
        end else begin
          seg_n = lae_pkg::SEGCNT_FINISHED;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [LW:0]   rem_sh;
  logic          q_bit;
  logic [LW-1:0] rem_n;
  logic [QW-1:0] dvd_n;
  logic [SW-1:0] quot_ext;
  logic          div_last;

  always_comb begin
    rem_sh   = {rem, dvd[QW-1]};
    q_bit    = (rem_sh >= {1'b0, div_len});
    rem_n    = q_bit ? LW'(rem_sh - {1'b0, div_len}) : rem_sh[LW-1:0];
    dvd_n    = {dvd[QW-2:0], q_bit};
    quot_ext = SW'(dvd_n);
    div_last = (div_cnt == CW'(QW - 1));
  end

  // level update with clamp to [0, 1.0]
  logic signed [SW:0] sum;
  logic [AW-1:0]      acc_sum;
  logic [2*lae_pkg::LEVEL_W-1:0] prod;

  always_comb begin
    sum = $signed({2'b00, acc}) + $signed({step[SW-1], step});
    if (sum < 0)                              acc_sum = '0;
    else if (sum > $signed({2'b00, ACC_FULL})) acc_sum = ACC_FULL;
    else                                       acc_sum = sum[AW-1:0];
    prod = lvl * lvl;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= lae_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != lae_pkg::ST_IDLE);
    unique case (state)
      lae_pkg::ST_IDLE: if (in_valid) state_next = launch ? lae_pkg::ST_DIV : lae_pkg::ST_ACC;
      lae_pkg::ST_DIV:  if (div_last) state_next = lae_pkg::ST_ACC;
      lae_pkg::ST_ACC:  state_next = lae_pkg::ST_MUL;
      lae_pkg::ST_MUL:  state_next = lae_pkg::ST_OUT;
      lae_pkg::ST_OUT:  if (out_load) state_next = lae_pkg::ST_IDLE;
      default: state_next = lae_pkg::ST_IDLE;
    endcase
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      seg   <= '0;
      ticks <= '0;
      acc   <= '0;
      step  <= '0;
    end else begin
      case (state)
        lae_pkg::ST_IDLE: if (in_take) begin
          seg   <= seg_n;
          ticks <= tk_n;
          acc   <= acc_a;
          step  <= step_n;
        end
        lae_pkg::ST_DIV: if (div_last) step <= div_neg ? -quot_ext : quot_ext;
        lae_pkg::ST_ACC: begin
          if (seg >= lae_pkg::SEGCNT_FINISHED) begin
            acc  <= '0;
            step <= '0;
          end else begin
            acc <= acc_sum;
          end
        end
        default: ;
      endcase
    end
  end

  // divider and per-tick working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == lae_pkg::ST_IDLE) begin
      div_cnt <= '0;
    end else if (state == lae_pkg::ST_DIV) begin
      div_cnt <= div_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lae_pkg::ST_IDLE: begin
        dvd     <= dvd_init;
        rem     <= '0;
        div_len <= len_sel;
        div_neg <= neg_init;
      end
      lae_pkg::ST_DIV: begin
        dvd <= dvd_n;
        rem <= rem_n;
      end
      lae_pkg::ST_ACC: begin
        if (seg >= lae_pkg::SEGCNT_FINISHED) begin
          lvl     <= '0;
          phase_r <= lae_pkg::PHASE_FINISHED;
          done_r  <= 1'b0;
        end else begin
          lvl     <= acc_sum[AW-1 -: lae_pkg::LEVEL_W];
          phase_r <= seg - 3'd1;
          done_r  <= (seg == lae_pkg::SEGCNT_LAST) && (ticks == TW'(1));
        end
      end
      lae_pkg::ST_MUL: sq <= prod[2*lae_pkg::LEVEL_W-2 -: lae_pkg::LEVEL_W];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level         <= lvl;
      level_squared <= sq;
      phase_now     <= phase_r;
      done_res      <= done_r;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= lae_pkg::LEVEL_MAX) && (level_squared <= level))
    else $error("level out of range");

  a_finished_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase_now == lae_pkg::PHASE_FINISHED) |-> (level == '0) && !done_res)
    else $error("finished result not silent");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> (phase_now == lae_pkg::PHASE_RELEASE))
    else $error("done outside release");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lae_pkg::ST_DIV) |-> (div_cnt < CW'(QW)) && (div_len != '0))
    else $error("divider ran past its bit count");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == lae_pkg::ST_IDLE) && out_valid)
    else $error("result load did not complete the tick");

endmodule
